// File: rtl/extra_data_list_walker_macros.svh
// Assertion macros shared by the extra-data list walker RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef EXTRA_DATA_LIST_WALKER_MACROS_SVH
`define EXTRA_DATA_LIST_WALKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EDLW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define EDLW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EDLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EDLW_ASSERT(lbl, clk, rst_n, prop)
`define EDLW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EDLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/edlw_pkg.sv
// Types, codes and tables of the extra-data list walker.
// No dependencies.
`default_nettype none
package edlw_pkg;

  typedef enum logic [5:0] {
    PH_COUNT       = 6'd0,
    PH_TYPE        = 6'd1,
    PH_ARR_VS      = 6'd2,
    PH_REF_A       = 6'd3,
    PH_REF_B       = 6'd4,
    PH_NAME_KIND   = 6'd5,
    PH_NAME_LEN    = 6'd6,
    PH_INL_HEAD    = 6'd7,
    PH_INL_FLAGS   = 6'd8,
    PH_G2_VS       = 6'd9,
    PH_G3_VS       = 6'd10,
    PH_G5_LEN      = 6'd11,
    PH_G9_PRESENT  = 6'd12,
    PH_G9_PARTS_VS = 6'd13,
    PH_G9_MORE     = 6'd14,
    PH_G9_MORPHS   = 6'd15,
    PH_G9_PRESETS  = 6'd16,
    PH_SKIP_ENTRY  = 6'd32,
    PH_SKIP_G0     = 6'd33,
    PH_SKIP_G1     = 6'd34,
    PH_SKIP_G2     = 6'd35,
    PH_SKIP_G3     = 6'd36,
    PH_SKIP_G4     = 6'd37,
    PH_SKIP_G5     = 6'd38,
    PH_SKIP_G6     = 6'd39,
    PH_SKIP_G7     = 6'd40,
    PH_SKIP_G8     = 6'd41,
    PH_SKIP_G9     = 6'd42,
    PH_SKIP_G10    = 6'd43,
    PH_SKIP_G11    = 6'd44,
    PH_SKIP_G12    = 6'd45,
    PH_S9A         = 6'd46,
    PH_S9B         = 6'd47,
    PH_S9C         = 6'd48,
    PH_S9D         = 6'd49
  } phase_e;

  typedef enum logic [2:0] {
    EK_EMPTY,
    EK_RIGHT,
    EK_LEFT,
    EK_FIXED,
    EK_ARRAY,
    EK_NAME,
    EK_INLINE,
    EK_UNKNOWN
  } entry_kind_e;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam int unsigned InlGroups = 13;
  localparam logic [31:0] NameKindMark = 32'hFFFF_FFFE;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        worn_right;
    logic        worn_left;
    logic [23:0] bytes_used;
  } out_t;

  typedef struct packed {
    entry_kind_e kind;
    logic [6:0]  size;
  } entry_info_t;

  function automatic entry_info_t entry_info(input logic [7:0] t);
    entry_info_t r;
    r.size = 7'd0;
    case (t) inside
      8'd22: r.kind = EK_RIGHT;
      8'd23: r.kind = EK_LEFT;
      8'd0, 8'd29, 8'd32, 8'd53, 8'd61: r.kind = EK_EMPTY;
      8'd31, 8'd44, 8'd73, 8'd77, 8'd84, 8'd150, 8'd156: begin
        r.kind = EK_FIXED; r.size = 7'd1;
      end
      8'd36, 8'd79: begin
        r.kind = EK_FIXED; r.size = 7'd2;
      end
      8'd26, 8'd28, 8'd33, 8'd34, 8'd35, 8'd56, 8'd69, 8'd72, 8'd101, 8'd104, 8'd112,
      8'd133, 8'd142, 8'd146, 8'd157, 8'd164: begin
        r.kind = EK_FIXED; r.size = 7'd3;
      end
      8'd30, 8'd37, 8'd39, 8'd40, 8'd47, 8'd83, 8'd85, 8'd89, 8'd93, 8'd160: begin
        r.kind = EK_FIXED; r.size = 7'd4;
      end
      8'd46, 8'd155: begin
        r.kind = EK_FIXED; r.size = 7'd5;
      end
      8'd102, 8'd159: begin
        r.kind = EK_FIXED; r.size = 7'd6;
      end
      8'd62, 8'd88, 8'd106, 8'd149: begin
        r.kind = EK_FIXED; r.size = 7'd7;
      end
      8'd176: begin
        r.kind = EK_FIXED; r.size = 7'd8;
      end
      8'd169: begin
        r.kind = EK_FIXED; r.size = 7'd12;
      end
      8'd25, 8'd42: begin
        r.kind = EK_FIXED; r.size = 7'd13;
      end
      8'd24: begin
        r.kind = EK_FIXED; r.size = 7'd19;
      end
      8'd43: begin
        r.kind = EK_FIXED; r.size = 7'd28;
      end
      8'd161: begin
        r.kind = EK_FIXED; r.size = 7'd88;
      end
      8'd27, 8'd68, 8'd52, 8'd120, 8'd111, 8'd136, 8'd140, 8'd91: r.kind = EK_ARRAY;
      8'd153: r.kind = EK_NAME;
      8'd45: r.kind = EK_INLINE;
      default: r.kind = EK_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [35:0] array_bytes(input logic [7:0] t, input logic [21:0] n);
    logic [35:0] w;
    w = 36'(n);
    case (t)
      8'd52, 8'd120: return w << 3;
      8'd111: return (w << 3) + (w << 1) + w;
      8'd136: return (w << 3) - w;
      8'd140: return (w << 1) + w;
      8'd91: return (w << 2) + 36'd4;
      default: return w << 2;
    endcase
  endfunction

  function automatic logic [31:0] inl_mask(input logic [3:0] k);
    case (k)
      4'd0: return 32'h0000_0001;
      4'd1: return 32'h0000_0002;
      4'd2: return 32'h0000_0040;
      4'd3: return 32'h0000_0010;
      4'd4: return 32'h0000_0008;
      4'd5: return 32'h0000_0020;
      4'd6: return 32'h0000_0200;
      4'd7: return 32'h0000_0400;
      4'd8: return 32'h0200_0000;
      4'd9: return 32'h0000_0800;
      4'd10: return 32'h0100_0000;
      4'd11: return 32'h0000_1000;
      4'd12: return 32'h0000_2000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [5:0] inl_size(input logic [3:0] k);
    case (k)
      4'd0: return 6'd6;
      4'd1: return 6'd24;
      4'd4: return 6'd20;
      4'd6: return 6'd52;
      4'd7: return 6'd3;
      4'd8: return 6'd6;
      4'd10: return 6'd1;
      4'd11: return 6'd3;
      4'd12: return 6'd3;
      default: return 6'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: rtl/edlw_walker.sv
// Input register, walk state and per-byte step logic of the list walker.
// Depends on edlw_pkg and extra_data_list_walker_macros.svh.
`default_nettype none
`include "extra_data_list_walker_macros.svh"
module edlw_walker #(
  parameter int BYTE_COUNT_WIDTH = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire edlw_pkg::in_t in_data_i,
  input  wire logic         space_i,
  output logic              res_valid_o,
  output edlw_pkg::out_t    res_o
);

  localparam logic [23:0] Cap = (BYTE_COUNT_WIDTH >= 24) ? 24'hFF_FFFF :
                                24'((64'd1 << BYTE_COUNT_WIDTH) - 64'd1);

  logic             in_vld_q, in_vld_d;
  edlw_pkg::in_t    in_q;
  logic             proc;
  logic             load;

  edlw_pkg::phase_e phase_q, phase_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  cbl_q, cbl_d;
  logic [21:0] ent_q, ent_d;
  logic [35:0] skip_q, skip_d;
  logic [31:0] fb_q, fb_d;
  logic [2:0]  fbl_q, fbl_d;
  logic [31:0] flags_q, flags_d;
  logic [1:0]  round_q, round_d;
  logic        ref_a_q, ref_a_d;
  logic        ref_b_q, ref_b_d;
  logic        mr_q, mr_d;
  logic        ml_q, ml_d;
  logic [23:0] cnt_q, cnt_d;
  logic        fin_q, fin_d;

  logic [7:0]  b;
  logic        vs_bad, vs_done;
  logic [23:0] vs_acc;
  logic [1:0]  vs_left, have;
  logic [21:0] vs_val;
  logic [31:0] ff_buf, or_buf;
  logic [2:0]  ff_left;
  logic        ff_done;
  logic        inl_req, ne_req, found;
  logic [3:0]  inl_k, sel;
  logic [1:0]  round_nx;
  edlw_pkg::entry_info_t info;

  assign proc       = in_vld_q && space_i;
  assign in_stall_o = in_vld_q && !proc;
  assign load       = in_valid_i && !in_stall_o;
  assign in_vld_d   = load ? 1'b1 : (proc ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    b = in_q.payload_byte;
    have = acc_q[1:0] - cbl_q + 2'd1;
    vs_bad = (cbl_q == 2'd0) && (b[1:0] == 2'd3);
    if (cbl_q == 2'd0) begin
      vs_acc  = {16'h0, b};
      vs_left = b[1:0];
    end else begin
      vs_acc  = acc_q | ((have == 2'd2) ? {b, 16'h0} : {8'h0, b, 8'h0});
      vs_left = cbl_q - 2'd1;
    end
    vs_done = !vs_bad && (vs_left == 2'd0);
    vs_val  = vs_acc[23:2];
    ff_buf  = {b, fb_q[31:8]};
    ff_left = (fbl_q != 3'd0) ? fbl_q - 3'd1 : 3'd0;
    ff_done = (ff_left == 3'd0);
    or_buf  = fb_q | {24'h0, b};
    round_nx = round_q + 2'd1;
    info = edlw_pkg::entry_info(b);
  end

  always_comb begin
    phase_d = phase_q; acc_d = acc_q; cbl_d = cbl_q; ent_d = ent_q; skip_d = skip_q;
    fb_d = fb_q; fbl_d = fbl_q; flags_d = flags_q; round_d = round_q;
    ref_a_d = ref_a_q; ref_b_d = ref_b_q; mr_d = mr_q; ml_d = ml_q;
    cnt_d = cnt_q; fin_d = fin_q;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.status = edlw_pkg::ST_COMPLETE;
    inl_req = 1'b0; inl_k = 4'd0; ne_req = 1'b0; found = 1'b0; sel = 4'd0;

    if (proc && !fin_q) begin
      cnt_d = (cnt_q < Cap) ? cnt_q + 24'd1 : cnt_q;
      case (phase_q)
        edlw_pkg::PH_COUNT: begin
          acc_d = vs_acc; cbl_d = vs_left;
          if (vs_bad) begin
            fin_d = 1'b1; res_valid_o = 1'b1; res_o.status = edlw_pkg::ST_BAD_COUNT;
          end else if (vs_done) begin
            ent_d = vs_val; ne_req = 1'b1;
          end
        end
        edlw_pkg::PH_TYPE: begin
          case (info.kind)
            edlw_pkg::EK_RIGHT: begin
              mr_d = 1'b1; ne_req = 1'b1;
            end
            edlw_pkg::EK_LEFT: begin
              ml_d = 1'b1; ne_req = 1'b1;
            end
            edlw_pkg::EK_EMPTY: ne_req = 1'b1;
            edlw_pkg::EK_FIXED: begin
              skip_d = 36'(info.size); phase_d = edlw_pkg::PH_SKIP_ENTRY;
            end
            edlw_pkg::EK_ARRAY: begin
              acc_d = '0; cbl_d = '0; fb_d = {24'h0, b}; phase_d = edlw_pkg::PH_ARR_VS;
            end
            edlw_pkg::EK_NAME: begin
              fb_d = '0; fbl_d = 3'd3; phase_d = edlw_pkg::PH_REF_A;
            end
            edlw_pkg::EK_INLINE: begin
              fbl_d = 3'd6; phase_d = edlw_pkg::PH_INL_HEAD;
            end
            default: begin
              fin_d = 1'b1; res_valid_o = 1'b1; res_o.status = edlw_pkg::ST_UNKNOWN;
            end
          endcase
        end
        edlw_pkg::PH_ARR_VS, edlw_pkg::PH_G2_VS, edlw_pkg::PH_G3_VS,
        edlw_pkg::PH_G9_PARTS_VS: begin
          acc_d = vs_acc; cbl_d = vs_left;
          if (vs_bad) begin
            fin_d = 1'b1; res_valid_o = 1'b1; res_o.status = edlw_pkg::ST_BAD_COUNT;
          end else if (vs_done) begin
            case (phase_q)
              edlw_pkg::PH_ARR_VS: begin
                skip_d = edlw_pkg::array_bytes(fb_q[7:0], vs_val);
                phase_d = edlw_pkg::PH_SKIP_ENTRY;
              end
              edlw_pkg::PH_G2_VS: begin
                skip_d = {12'h0, vs_val, 2'b00}; phase_d = edlw_pkg::PH_SKIP_G2;
              end
              edlw_pkg::PH_G3_VS: begin
                skip_d = 36'(vs_val) + {13'h0, vs_val, 1'b0};
                phase_d = edlw_pkg::PH_SKIP_G3;
              end
              default: begin
                skip_d = 36'(vs_val) + {13'h0, vs_val, 1'b0};
                phase_d = edlw_pkg::PH_S9B;
              end
            endcase
          end
        end
        edlw_pkg::PH_REF_A, edlw_pkg::PH_REF_B: begin
          fb_d = or_buf; fbl_d = ff_left;
          if (ff_done) begin
            fb_d = '0;
            if (phase_q == edlw_pkg::PH_REF_A) begin
              ref_a_d = (or_buf == 32'h0); fbl_d = 3'd3; phase_d = edlw_pkg::PH_REF_B;
            end else begin
              ref_b_d = (or_buf == 32'h0); fbl_d = 3'd4; phase_d = edlw_pkg::PH_NAME_KIND;
            end
          end
        end
        edlw_pkg::PH_NAME_KIND: begin
          fb_d = ff_buf; fbl_d = ff_left;
          if (ff_done) begin
            if (ref_a_q && ref_b_q && ff_buf == edlw_pkg::NameKindMark) begin
              fb_d = '0; fbl_d = 3'd2; phase_d = edlw_pkg::PH_NAME_LEN;
            end else begin
              ne_req = 1'b1;
            end
          end
        end
        edlw_pkg::PH_NAME_LEN, edlw_pkg::PH_G5_LEN: begin
          fb_d = ff_buf; fbl_d = ff_left;
          if (ff_done) begin
            skip_d = {20'h0, ff_buf[31:16]};
            phase_d = (phase_q == edlw_pkg::PH_NAME_LEN) ? edlw_pkg::PH_SKIP_ENTRY :
                                                           edlw_pkg::PH_SKIP_G5;
          end
        end
        edlw_pkg::PH_INL_HEAD: begin
          fbl_d = ff_left;
          if (ff_done) begin
            fb_d = '0; fbl_d = 3'd4; phase_d = edlw_pkg::PH_INL_FLAGS;
          end
        end
        edlw_pkg::PH_INL_FLAGS: begin
          fb_d = ff_buf; fbl_d = ff_left;
          if (ff_done) begin
            flags_d = ff_buf; inl_req = 1'b1; inl_k = 4'd0;
          end
        end
        edlw_pkg::PH_G9_PRESENT: begin
          if (b != 8'h0) begin
            skip_d = 36'd10; phase_d = edlw_pkg::PH_S9A;
          end else begin
            inl_req = 1'b1; inl_k = 4'd10;
          end
        end
        edlw_pkg::PH_G9_MORE: begin
          if (b != 8'h0) begin
            fb_d = '0; fbl_d = 3'd4; phase_d = edlw_pkg::PH_G9_MORPHS;
          end else begin
            inl_req = 1'b1; inl_k = 4'd10;
          end
        end
        edlw_pkg::PH_G9_MORPHS, edlw_pkg::PH_G9_PRESETS: begin
          fb_d = ff_buf; fbl_d = ff_left;
          if (ff_done) begin
            skip_d = {2'b00, ff_buf, 2'b00};
            phase_d = (phase_q == edlw_pkg::PH_G9_MORPHS) ? edlw_pkg::PH_S9C :
                                                            edlw_pkg::PH_S9D;
          end
        end
        default: begin
          if (skip_q != 36'h0) begin
            skip_d = skip_q - 36'd1;
          end
        end
      endcase

      if (!fin_d && !inl_req && !ne_req && phase_d >= edlw_pkg::PH_SKIP_ENTRY &&
          skip_d == 36'h0) begin
        case (phase_d)
          edlw_pkg::PH_SKIP_ENTRY: ne_req = 1'b1;
          edlw_pkg::PH_SKIP_G3: begin
            round_d = round_nx;
            if (round_nx < 2'd3) begin
              acc_d = '0; cbl_d = '0; phase_d = edlw_pkg::PH_G3_VS;
            end else begin
              inl_req = 1'b1; inl_k = 4'd4;
            end
          end
          edlw_pkg::PH_S9A: begin
            acc_d = '0; cbl_d = '0; phase_d = edlw_pkg::PH_G9_PARTS_VS;
          end
          edlw_pkg::PH_S9B: phase_d = edlw_pkg::PH_G9_MORE;
          edlw_pkg::PH_S9C: begin
            fb_d = '0; fbl_d = 3'd4; phase_d = edlw_pkg::PH_G9_PRESETS;
          end
          edlw_pkg::PH_S9D: begin
            inl_req = 1'b1; inl_k = 4'd10;
          end
          default: begin
            if (phase_d >= edlw_pkg::PH_SKIP_G0 && phase_d <= edlw_pkg::PH_SKIP_G12) begin
              inl_req = 1'b1;
              inl_k = 4'(6'(phase_d) - 6'(edlw_pkg::PH_SKIP_G0) + 6'd1);
            end else begin
              ne_req = 1'b1;
            end
          end
        endcase
      end

      if (inl_req) begin
        for (int j = 0; j < edlw_pkg::InlGroups; j++) begin
          if (!found && 4'(j) >= inl_k && |(flags_d & edlw_pkg::inl_mask(4'(j)))) begin
            found = 1'b1; sel = 4'(j);
          end
        end
        if (!found) begin
          ne_req = 1'b1;
        end else if (edlw_pkg::inl_size(sel) != 6'd0) begin
          skip_d = 36'(edlw_pkg::inl_size(sel));
          phase_d = edlw_pkg::phase_e'(6'(edlw_pkg::PH_SKIP_G0) + 6'(sel));
        end else begin
          case (sel)
            4'd2: begin
              acc_d = '0; cbl_d = '0; phase_d = edlw_pkg::PH_G2_VS;
            end
            4'd3: begin
              round_d = '0; acc_d = '0; cbl_d = '0; phase_d = edlw_pkg::PH_G3_VS;
            end
            4'd5: begin
              fb_d = '0; fbl_d = 3'd2; phase_d = edlw_pkg::PH_G5_LEN;
            end
            default: phase_d = edlw_pkg::PH_G9_PRESENT;
          endcase
        end
      end

      if (ne_req) begin
        if (ent_d == 22'h0) begin
          fin_d = 1'b1; res_valid_o = 1'b1; res_o.status = edlw_pkg::ST_COMPLETE;
        end else begin
          ent_d = ent_d - 22'd1; phase_d = edlw_pkg::PH_TYPE;
        end
      end
    end

    if (proc && in_q.payload_end && !fin_d) begin
      fin_d = 1'b1; res_valid_o = 1'b1; res_o.status = edlw_pkg::ST_TRUNCATED;
    end

    res_o.worn_right = mr_d;
    res_o.worn_left  = ml_d;
    res_o.bytes_used = cnt_d;

    if (proc && in_q.payload_end) begin
      phase_d = edlw_pkg::PH_COUNT; acc_d = '0; cbl_d = '0; ent_d = '0; skip_d = '0;
      fb_d = '0; fbl_d = '0; flags_d = '0; round_d = '0; ref_a_d = 1'b0; ref_b_d = 1'b0;
      mr_d = 1'b0; ml_d = 1'b0; cnt_d = '0; fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= edlw_pkg::PH_COUNT;
      acc_q <= '0; cbl_q <= '0; ent_q <= '0; skip_q <= '0; fb_q <= '0; fbl_q <= '0;
      flags_q <= '0; round_q <= '0; ref_a_q <= 1'b0; ref_b_q <= 1'b0;
      mr_q <= 1'b0; ml_q <= 1'b0; cnt_q <= '0; fin_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q <= acc_d; cbl_q <= cbl_d; ent_q <= ent_d; skip_q <= skip_d; fb_q <= fb_d;
      fbl_q <= fbl_d; flags_q <= flags_d; round_q <= round_d; ref_a_q <= ref_a_d;
      ref_b_q <= ref_b_d; mr_q <= mr_d; ml_q <= ml_d; cnt_q <= cnt_d; fin_q <= fin_d;
    end
  end

  `EDLW_ASSERT_IMP(a_res_needs_item, clk_i, rst_ni, res_valid_o, proc)
  `EDLW_ASSERT_NEXT(a_end_restarts, clk_i, rst_ni, proc && in_q.payload_end,
                    !fin_q && phase_q == edlw_pkg::PH_COUNT && cnt_q == 24'h0)
  `EDLW_ASSERT_IMP(a_quiet_after_finish, clk_i, rst_ni,
                   fin_q && proc && !in_q.payload_end, !res_valid_o)

endmodule
`default_nettype wire

// File: rtl/edlw_out_buf.sv
// Two-entry result buffer that decouples the walker from the output stall.
// Depends on edlw_pkg and extra_data_list_walker_macros.svh.
`default_nettype none
`include "extra_data_list_walker_macros.svh"
module edlw_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire edlw_pkg::out_t push_data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output edlw_pkg::out_t      out_data_o
);

  logic [1:0]     cnt_q, cnt_d;
  edlw_pkg::out_t slot0_q, slot0_d;
  edlw_pkg::out_t slot1_q, slot1_d;
  logic           pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign space_o     = (cnt_q != 2'd2);
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    slot0_d = pop ? slot1_q : slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q - {1'b0, pop};
    if (push_i) begin
      if (cnt_d == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  `EDLW_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3)
  `EDLW_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, cnt_q == 2'd2 && !pop, !push_i)
  `EDLW_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && !push_i,
                    cnt_q == $past(cnt_q) - 2'd1)

endmodule
`default_nettype wire

// File: rtl/extra_data_list_walker.sv
// Extra-data list walker: one byte per unstalled cycle, at most one result per payload.
// The step reads the input register and pushes any result into the result buffer.
// Throughput: 1 byte per cycle if the buffer has space, set by the combinational step.
// A two-entry result buffer keeps input flowing while a result waits.
// Reset clears the walk state and the buffers; a new list starts at the next byte.
`default_nettype none
module extra_data_list_walker #(
  parameter int BYTE_COUNT_WIDTH = 24
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire edlw_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output edlw_pkg::out_t      out_data_o
);

  logic           space;
  logic           res_valid;
  edlw_pkg::out_t res;

  edlw_walker #(
    .BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .space_i    (space),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  edlw_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (space),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
